// ===== rtl/ihex_pkg.sv =====
// Shared types, character codes and helpers for the hex record decoder.
package ihex_pkg;

  // Record length limit, capped at the data buffer depth
  localparam int unsigned BufBytes       = 16;
  localparam int unsigned BufWords       = BufBytes / 4;
  localparam int unsigned MaxRecordBytes = 16;
  localparam int unsigned DataLimit      = (MaxRecordBytes < BufBytes) ? MaxRecordBytes
                                                                       : BufBytes;
  localparam logic [7:0] PadReset = 8'hFF;

  // Character codes
  localparam logic [7:0] CharColon = 8'h3A;
  localparam logic [7:0] CharCr    = 8'h0D;
  localparam logic [7:0] CharLf    = 8'h0A;
  localparam logic [7:0] CharNine  = 8'h39;
  localparam logic [7:0] CharSeven = 8'h37;
  localparam logic [7:0] CharZero  = 8'h30;

  // Record types
  localparam logic [7:0] RecData   = 8'h00;
  localparam logic [7:0] RecEof    = 8'h01;
  localparam logic [7:0] RecExtLin = 8'h04;

  typedef enum logic [1:0] {
    PH_WAIT = 2'd0,
    PH_LINE = 2'd1,
    PH_DONE = 2'd2,
    PH_HALT = 2'd3
  } phase_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_DONE     = 3'd1,
    ST_NO_START = 3'd2,
    ST_BAD_SUM  = 3'd3,
    ST_TOO_LONG = 3'd4,
    ST_NO_EOF   = 3'd5
  } status_e;

  typedef enum logic {
    KIND_WORD   = 1'b0,
    KIND_STATUS = 1'b1
  } kind_e;

  // Decode one hex digit; no validity check, low four bits kept
  function automatic logic [3:0] hex_value(input logic [7:0] c);
    logic [7:0] v;
    v = (c > CharNine) ? (c - CharSeven) : (c - CharZero);
    return v[3:0];
  endfunction

endpackage

// ===== rtl/intel_hex_record_decoder.sv =====
// Intel HEX record decoder: character parser, word emitter and output register.
//
// Takes one text character per cycle on the slave stream when ready (tuser high
// marks end of file). Characters that cause no result, and those that cause a
// single status item, are taken back to back at one per cycle unless the master
// side stalls. A line end that closes a good data record causes ceil(count/4)
// word writes plus a status item; the emitter puts one of these into the output
// register per cycle when it is free, and the next character is taken in the
// cycle the status item moves into it, so the slave side stalls while the words
// (at most 4) go out. The last item of each burst sits in the output register
// while the next character is already taken. After done or an error every
// character is taken and dropped until reset. pad_byte may be written at any
// time the block is idle; the configuration channel is always ready.
module intel_hex_record_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration: pad_byte
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_data_i,
  // Text input
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] text_char
  input  logic        s_axis_tuser_i,   // [0] end_of_input
  // Results
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [71:0] m_axis_tdata_o,   // [31:0] write_address, [63:32] write_word,
                                        // [66:64] status_code, [71:67] zero
  output logic        m_axis_tuser_o,   // [0] item_kind
  output logic        m_axis_tlast_o    // last_of_run
);

  localparam int unsigned WIdxW = $clog2(ihex_pkg::BufWords);

  // Parser state
  ihex_pkg::phase_e phase_q, phase_d;
  logic             nib_pend_q, nib_pend_d;
  logic [3:0]       hi_nib_q, hi_nib_d;
  logic [4:0]       pos_q, pos_d;
  logic [4:0]       len_q, len_d;
  logic [15:0]      offset_q, offset_d;
  logic [7:0]       rec_kind_q, rec_kind_d;
  logic [7:0]       sum_q, sum_d;
  logic [15:0]      ext_base_q, ext_base_d;
  logic [7:0]       pad_q;
  logic [31:0]      buf_word_q [ihex_pkg::BufWords];

  // Buffer write port
  logic             buf_we;
  logic [3:0]       buf_idx;

  // Result of the current transfer
  logic             res_valid;
  ihex_pkg::status_e res_code;
  logic [2:0]       res_words;

  // Emitter
  logic [2:0]        words_left_q, words_left_d;
  logic [WIdxW-1:0]  word_idx_q, word_idx_d;
  logic [31:0]       base_q, base_d;
  logic              stat_pend_q, stat_pend_d;
  ihex_pkg::status_e code_q, code_d;
  logic              out_load;

  // Output register
  logic              out_valid_q;
  ihex_pkg::kind_e   out_kind_q;
  logic [31:0]       out_addr_q, out_word_q;
  ihex_pkg::status_e out_code_q;
  logic              out_last_q;

  logic              s_accept;
  logic [3:0]        nib;
  logic [7:0]        byte_val;
  logic [5:0]        pos_ext, len_plus5, len_plus4, len_plus3;
  logic              line_good, is_eol;
  logic [31:0]       em_word;
  logic [31:0]       em_addr;

  assign cfg_ready_o     = 1'b1;
  assign s_axis_tready_o = (words_left_q == 3'd0) && (!stat_pend_q || out_load);
  assign s_accept        = s_axis_tvalid_i && s_axis_tready_o;

  assign nib       = ihex_pkg::hex_value(s_axis_tdata_i);
  assign byte_val  = {hi_nib_q, nib};
  assign pos_ext   = {1'b0, pos_q};
  assign len_plus5 = {1'b0, len_q} + 6'd5;
  assign len_plus4 = {1'b0, len_q} + 6'd4;
  assign len_plus3 = {1'b0, len_q} + 6'd3;
  assign line_good = !nib_pend_q && (pos_ext == len_plus5) && (sum_q == 8'd0);
  assign is_eol    = (s_axis_tdata_i == ihex_pkg::CharCr) ||
                     (s_axis_tdata_i == ihex_pkg::CharLf);
  assign buf_idx   = pos_q[3:0] - 4'd4;

  // Parser next state: one character per transfer
  always_comb begin : parse_next
    phase_d    = phase_q;
    nib_pend_d = nib_pend_q;
    hi_nib_d   = hi_nib_q;
    pos_d      = pos_q;
    len_d      = len_q;
    offset_d   = offset_q;
    rec_kind_d = rec_kind_q;
    sum_d      = sum_q;
    ext_base_d = ext_base_q;
    buf_we     = 1'b0;
    if (s_accept && (phase_q == ihex_pkg::PH_WAIT || phase_q == ihex_pkg::PH_LINE)) begin
      if (s_axis_tuser_i) begin
        // End of file: done only on a complete, good EOF record
        if (phase_q == ihex_pkg::PH_LINE && line_good && rec_kind_q == ihex_pkg::RecEof) begin
          phase_d = ihex_pkg::PH_DONE;
        end else begin
          phase_d = ihex_pkg::PH_HALT;
        end
      end else if (phase_q == ihex_pkg::PH_WAIT) begin
        // Skip blank line ends, open a record on the start code, halt on anything else
        if (!is_eol) begin
          if (s_axis_tdata_i != ihex_pkg::CharColon) begin
            phase_d = ihex_pkg::PH_HALT;
          end else begin
            nib_pend_d = 1'b0;
            hi_nib_d   = 4'd0;
            pos_d      = 5'd0;
            len_d      = 5'd0;
            offset_d   = 16'd0;
            rec_kind_d = 8'd0;
            sum_d      = 8'd0;
            phase_d    = ihex_pkg::PH_LINE;
          end
        end
      end else if (is_eol) begin
        // Close the line
        if (!line_good) begin
          phase_d = ihex_pkg::PH_HALT;
        end else if (rec_kind_q == ihex_pkg::RecEof) begin
          phase_d = ihex_pkg::PH_DONE;
        end else begin
          if (rec_kind_q == ihex_pkg::RecExtLin) begin
            ext_base_d[15:8] = (len_q > 5'd0) ? buf_word_q[0][7:0] : 8'd0;
            ext_base_d[7:0]  = (len_q > 5'd1) ? buf_word_q[0][15:8] : 8'd0;
          end
          phase_d = ihex_pkg::PH_WAIT;
        end
      end else if (!nib_pend_q) begin
        hi_nib_d   = nib;
        nib_pend_d = 1'b1;
      end else begin
        nib_pend_d = 1'b0;
        if (pos_ext >= len_plus5) begin
          phase_d = ihex_pkg::PH_HALT;
        end else begin
          sum_d = sum_q + byte_val;
          pos_d = pos_q + 5'd1;
          case (pos_q)
            5'd0: begin
              len_d = byte_val[4:0];
              if (byte_val > 8'(ihex_pkg::DataLimit)) begin
                phase_d = ihex_pkg::PH_HALT;
              end
            end
            5'd1: offset_d[15:8] = byte_val;
            5'd2: offset_d[7:0]  = byte_val;
            5'd3: rec_kind_d     = byte_val;
            default: begin
              if (pos_ext < len_plus4) begin
                buf_we = 1'b1;
              end
            end
          endcase
        end
      end
    end
  end

  // Parser outputs: what the transfer gives to the emitter
  always_comb begin : parse_out
    res_valid = 1'b0;
    res_code  = ihex_pkg::ST_OK;
    res_words = 3'd0;
    if (phase_q == ihex_pkg::PH_WAIT || phase_q == ihex_pkg::PH_LINE) begin
      if (s_axis_tuser_i) begin
        res_valid = 1'b1;
        res_code  = (phase_q == ihex_pkg::PH_LINE && line_good &&
                     rec_kind_q == ihex_pkg::RecEof) ? ihex_pkg::ST_DONE
                                                     : ihex_pkg::ST_NO_EOF;
      end else if (phase_q == ihex_pkg::PH_WAIT) begin
        if (!is_eol && s_axis_tdata_i != ihex_pkg::CharColon) begin
          res_valid = 1'b1;
          res_code  = ihex_pkg::ST_NO_START;
        end
      end else if (is_eol) begin
        res_valid = 1'b1;
        if (!line_good) begin
          res_code = ihex_pkg::ST_BAD_SUM;
        end else if (rec_kind_q == ihex_pkg::RecEof) begin
          res_code = ihex_pkg::ST_DONE;
        end else if (rec_kind_q == ihex_pkg::RecData) begin
          res_words = len_plus3[4:2];
        end
      end else if (nib_pend_q) begin
        if (pos_ext >= len_plus5) begin
          res_valid = 1'b1;
          res_code  = ihex_pkg::ST_TOO_LONG;
        end else if (pos_q == 5'd0 && byte_val > 8'(ihex_pkg::DataLimit)) begin
          res_valid = 1'b1;
          res_code  = ihex_pkg::ST_TOO_LONG;
        end
      end
    end
  end

  // Parser registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= ihex_pkg::PH_WAIT;
      nib_pend_q <= 1'b0;
      hi_nib_q   <= 4'd0;
      pos_q      <= 5'd0;
      len_q      <= 5'd0;
      offset_q   <= 16'd0;
      rec_kind_q <= 8'd0;
      sum_q      <= 8'd0;
      ext_base_q <= 16'd0;
      pad_q      <= ihex_pkg::PadReset;
    end else begin
      phase_q    <= phase_d;
      nib_pend_q <= nib_pend_d;
      hi_nib_q   <= hi_nib_d;
      pos_q      <= pos_d;
      len_q      <= len_d;
      offset_q   <= offset_d;
      rec_kind_q <= rec_kind_d;
      sum_q      <= sum_d;
      ext_base_q <= ext_base_d;
      if (cfg_valid_i && cfg_ready_o) begin
        pad_q <= cfg_data_i;
      end
    end
  end

  // Data buffer, one byte lane written per transfer
  always_ff @(posedge clk_i) begin
    if (buf_we) begin
      buf_word_q[buf_idx[3:2]][8*buf_idx[1:0] +: 8] <= byte_val;
    end
  end

  // Assemble the next word, padding bytes past the record length
  always_comb begin : word_build
    em_word = buf_word_q[word_idx_q];
    for (int k = 0; k < 4; k++) begin
      if ({1'b0, word_idx_q, 2'(k)} >= len_q) begin
        em_word[8*k +: 8] = pad_q;
      end
    end
    em_addr = base_q + {28'd0, word_idx_q, 2'b00};
  end

  // Emitter: words first, then the status item
  assign out_load = (!out_valid_q || m_axis_tready_i) &&
                    ((words_left_q != 3'd0) || stat_pend_q);

  always_comb begin : emit_next
    words_left_d = words_left_q;
    word_idx_d   = word_idx_q;
    base_d       = base_q;
    stat_pend_d  = stat_pend_q;
    code_d       = code_q;
    if (s_accept && res_valid) begin
      words_left_d = res_words;
      word_idx_d   = '0;
      base_d       = {ext_base_q, offset_q};
      stat_pend_d  = 1'b1;
      code_d       = res_code;
    end else if (out_load) begin
      if (words_left_q != 3'd0) begin
        words_left_d = words_left_q - 3'd1;
        word_idx_d   = word_idx_q + 1'b1;
      end else begin
        stat_pend_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      words_left_q <= 3'd0;
      stat_pend_q  <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      words_left_q <= words_left_d;
      stat_pend_q  <= stat_pend_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Emitter payload and output register
  always_ff @(posedge clk_i) begin
    word_idx_q <= word_idx_d;
    base_q     <= base_d;
    code_q     <= code_d;
    if (out_load) begin
      if (words_left_q != 3'd0) begin
        out_kind_q <= ihex_pkg::KIND_WORD;
        out_addr_q <= em_addr;
        out_word_q <= em_word;
        out_code_q <= ihex_pkg::ST_OK;
        out_last_q <= 1'b0;
      end else begin
        out_kind_q <= ihex_pkg::KIND_STATUS;
        out_addr_q <= 32'd0;
        out_word_q <= 32'd0;
        out_code_q <= code_q;
        out_last_q <= 1'b1;
      end
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {5'd0, out_code_q, out_word_q, out_addr_q};
  assign m_axis_tuser_o  = out_kind_q;
  assign m_axis_tlast_o  = out_last_q;

  // Pending words always end in a status item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (words_left_q != 3'd0) |-> stat_pend_q)
    else $error("word burst without a closing status");

  // Once done or halted, no new results appear
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((phase_q == ihex_pkg::PH_DONE || phase_q == ihex_pkg::PH_HALT) && !stat_pend_q)
    |=> !stat_pend_q)
    else $error("result raised after the parser stopped");

  // Byte position never runs past the checksum slot
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == ihex_pkg::PH_LINE) |-> (pos_ext <= len_plus5))
    else $error("byte position beyond record end");

  // Word items are never last and carry no status
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_kind_q == ihex_pkg::KIND_WORD) |->
    (!out_last_q && out_code_q == ihex_pkg::ST_OK))
    else $error("word item marked last or with a status code");

endmodule
